[hw/rtl/lfu_favourite_item_table_unit_macros.svh]
// assertion macros shared by the lfu favourite item table rtl
// used by lfit_cell and lfu_favourite_item_table_unit, expects clk_i and rst_ni in scope
`ifndef LFU_FAVOURITE_ITEM_TABLE_UNIT_MACROS_SVH
`define LFU_FAVOURITE_ITEM_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define LFIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfit assertion failed");

// next-cycle implication
`define LFIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfit assertion failed");

`endif

[hw/rtl/lfit_pkg.sv]
// types and constants for the lfu favourite item table
// no dependencies
`timescale 1ns / 1ps

package lfit_pkg;

  localparam int unsigned ENTRIES = 4;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hffff;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // partial result handed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
    idx_t match_idx;
    cnt_t min_cnt;
    idx_t min_idx;
    cnt_t max_cnt;
    key_t max_key;
  } scan_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic en;
    logic fresh;
    idx_t idx;
  } upd_t;

endpackage

[hw/rtl/lfit_cell.sv]
// one table slot: key and use count, plus one stage of the scan chain
// depends on lfit_pkg and lfu_favourite_item_table_unit_macros.svh
`timescale 1ns / 1ps
`include "lfu_favourite_item_table_unit_macros.svh"

module lfit_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfit_pkg::idx_t      idx_i,
  input  lfit_pkg::key_t      key_i,
  input  lfit_pkg::upd_t      upd_i,
  input  lfit_pkg::scan_t     scan_i,
  output lfit_pkg::scan_t     scan_o
);

  lfit_pkg::key_t  key_q, key_d;
  lfit_pkg::cnt_t  cnt_q, cnt_d;
  lfit_pkg::scan_t scan_q, scan_d;
  logic            hit;

  assign hit = upd_i.en && (upd_i.idx == idx_i);

  always_comb begin
    key_d = key_q;
    cnt_d = cnt_q;
    if (hit) begin
      if (upd_i.fresh) begin
        key_d = key_i;
        cnt_d = lfit_pkg::cnt_t'(1);
      end else if (cnt_q != lfit_pkg::CNT_MAX) begin
        cnt_d = cnt_q + lfit_pkg::cnt_t'(1);
      end
    end
  end

  always_comb begin
    scan_d       = scan_q;
    scan_d.valid = 1'b0;
    if (scan_i.valid) begin
      scan_d = scan_i;
      if (!scan_i.found && (key_q == key_i)) begin
        scan_d.found     = 1'b1;
        scan_d.match_idx = idx_i;
      end
      if (cnt_q < scan_i.min_cnt) begin
        scan_d.min_cnt = cnt_q;
        scan_d.min_idx = idx_i;
      end
      if (cnt_q > scan_i.max_cnt) begin
        scan_d.max_cnt = cnt_q;
        scan_d.max_key = key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      cnt_q  <= '0;
      scan_q <= '0;
    end else begin
      key_q  <= key_d;
      cnt_q  <= cnt_d;
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

  `LFIT_ASSERT_NEXT(a_hit_count_nonzero, hit, cnt_q != '0)
  `LFIT_ASSERT_NOW(a_out_follows_in, scan_q.valid, $past(scan_i.valid))
  `LFIT_ASSERT_NEXT(a_match_kept, scan_i.valid && scan_i.found,
                    scan_q.found && (scan_q.match_idx == $past(scan_i.match_idx)))

endmodule

[hw/rtl/lfu_favourite_item_table_unit.sv]
// Least-frequently-used table of 64-bit item keys with a 16-bit saturating use
// count per slot, reporting the most used key after every beat. The slots form
// a chain of cells; a scan token walks the chain one cell per cycle. A key whose
// low byte is not zero costs two walks (match and minimum, then maximum); a key
// whose low byte is zero skips the first walk. One item is in work at a time;
// a finished result waits in the output register while the next item starts.
// depends on lfit_pkg, lfit_cell and lfu_favourite_item_table_unit_macros.svh
`timescale 1ns / 1ps
`include "lfu_favourite_item_table_unit_macros.svh"

module lfu_favourite_item_table_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [63:0]          item_key_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          favourite_key_o,
  output logic [15:0]          favourite_count_o,
  output logic                 has_favourite_o,
  output logic                 was_ignored_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_LAUNCH1 = 6'b000010,
    S_WAIT1   = 6'b000100,
    S_LAUNCH2 = 6'b001000,
    S_WAIT2   = 6'b010000,
    S_FINISH  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  lfit_pkg::key_t  key_q, key_d;
  logic            ign_q, ign_d;
  lfit_pkg::scan_t res_q, res_d;
  lfit_pkg::scan_t head;
  lfit_pkg::scan_t tail;
  lfit_pkg::upd_t  upd;
  lfit_pkg::scan_t chain [lfit_pkg::ENTRIES+1];

  logic            out_free;
  logic            in_beat;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign tail       = chain[lfit_pkg::ENTRIES];
  assign chain[0]   = head;

  always_comb begin
    head           = '0;
    head.valid     = (state_q == S_LAUNCH1) || (state_q == S_LAUNCH2);
    head.min_cnt   = lfit_pkg::CNT_MAX;
  end

  always_comb begin
    upd       = '0;
    upd.en    = (state_q == S_WAIT1) && tail.valid;
    upd.fresh = !tail.found;
    upd.idx   = tail.found ? tail.match_idx : tail.min_idx;
  end

  for (genvar g = 0; g < lfit_pkg::ENTRIES; g++) begin : g_cell
    lfit_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (lfit_pkg::idx_t'(g)),
      .key_i  (key_q),
      .upd_i  (upd),
      .scan_i (chain[g]),
      .scan_o (chain[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    ign_d   = ign_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          key_d   = item_key_i;
          ign_d   = (item_key_i[7:0] == 8'h00);
          state_d = (item_key_i[7:0] == 8'h00) ? S_LAUNCH2 : S_LAUNCH1;
        end
      end
      S_LAUNCH1: state_d = S_WAIT1;
      S_WAIT1: begin
        if (tail.valid) state_d = S_LAUNCH2;
      end
      S_LAUNCH2: state_d = S_WAIT2;
      S_WAIT2: begin
        if (tail.valid) begin
          res_d   = tail;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      key_q   <= '0;
      ign_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
      ign_q   <= ign_d;
      res_q   <= res_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o       <= 1'b0;
      favourite_key_o   <= '0;
      favourite_count_o <= '0;
      has_favourite_o   <= 1'b0;
      was_ignored_o     <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= (state_q == S_FINISH);
      if (state_q == S_FINISH) begin
        favourite_key_o   <= res_q.max_key;
        favourite_count_o <= res_q.max_cnt;
        has_favourite_o   <= (res_q.max_cnt != '0);
        was_ignored_o     <= ign_q;
      end
    end
  end

  `LFIT_ASSERT_NOW(a_tail_in_wait, tail.valid,
                   (state_q == S_WAIT1) || (state_q == S_WAIT2))
  `LFIT_ASSERT_NOW(a_fav_count, has_favourite_o, favourite_count_o != '0)
  `LFIT_ASSERT_NOW(a_no_fav_zero, !has_favourite_o,
                   (favourite_key_o == '0) && (favourite_count_o == '0))

endmodule
